@@ sv/hrp_pkg.sv @@
`default_nettype none

package hrp_pkg;

    localparam int BYTE_W     = 8;
    localparam int IN_TDATA_W = 8;
    localparam int RES_W      = 14;
    localparam int OUT_TDATA_W = 16;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] GET_LEN  = 3'd3;
    localparam logic [2:0] POST_LEN = 3'd4;
    localparam logic [2:0] METH_SAT = 3'd5;
    localparam logic [3:0] VER_LEN  = 4'd8;
    localparam logic [3:0] VER_SAT  = 4'd9;
    localparam logic [3:0] KEY_LEN  = 4'd10;
    localparam logic [3:0] KEY_SAT  = 4'd11;
    localparam logic [3:0] VAL_LEN  = 4'd10;
    localparam logic [3:0] VAL_SAT  = 4'd11;
    localparam logic [1:0] PATH_SAT = 2'd2;

    typedef enum logic [1:0] {
        STATUS_INCOMPLETE = 2'd0,
        STATUS_DONE       = 2'd1,
        STATUS_ERROR      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_REQ  = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_DONE = 4'b0100,
        PH_ERR  = 4'b1000
    } phase_t;

    typedef enum logic [4:0] {
        STEP_METHOD = 5'b00001,
        STEP_GAP1   = 5'b00010,
        STEP_PATH   = 5'b00100,
        STEP_GAP2   = 5'b01000,
        STEP_VER    = 5'b10000
    } step_t;

    typedef struct packed {
        phase_t     phase;
        step_t      step;
        logic       cr_pending;
        logic       line_truncated;
        logic       line_empty;
        logic [2:0] method_pos;
        logic       get_mismatch;
        logic       post_mismatch;
        logic [1:0] path_len;
        logic       root_path;
        logic [3:0] version_pos;
        logic       version_mismatch;
        logic       colon_seen;
        logic [3:0] key_pos;
        logic       key_mismatch;
        logic       value_started;
        logic [3:0] value_pos;
        logic       value_mismatch;
        logic       keep_alive;
        logic       post;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:            PH_REQ,
        step:             STEP_METHOD,
        cr_pending:       1'b0,
        line_truncated:   1'b0,
        line_empty:       1'b1,
        method_pos:       3'd0,
        get_mismatch:     1'b0,
        post_mismatch:    1'b0,
        path_len:         2'd0,
        root_path:        1'b0,
        version_pos:      4'd0,
        version_mismatch: 1'b0,
        colon_seen:       1'b0,
        key_pos:          4'd0,
        key_mismatch:     1'b0,
        value_started:    1'b0,
        value_pos:        4'd0,
        value_mismatch:   1'b0,
        keep_alive:       1'b0,
        post:             1'b0
    };

    typedef struct packed {
        logic       path_is_root;
        logic       path_byte_valid;
        logic [7:0] path_byte;
        logic       keep_alive;
        logic       method_is_post;
        status_t    status;
    } result_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] get_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h47;
            3'd1:    return 8'h45;
            3'd2:    return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] pos);
        case (pos)
            3'd0:    return 8'h50;
            3'd1:    return 8'h4F;
            3'd2:    return 8'h53;
            3'd3:    return 8'h54;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return 8'h48;
            4'd1:    return 8'h54;
            4'd2:    return 8'h54;
            4'd3:    return 8'h50;
            4'd4:    return 8'h2F;
            4'd5:    return 8'h31;
            4'd6:    return 8'h2E;
            4'd7:    return 8'h31;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return 8'h43;
            4'd1:    return 8'h6F;
            4'd2:    return 8'h6E;
            4'd3:    return 8'h6E;
            4'd4:    return 8'h65;
            4'd5:    return 8'h63;
            4'd6:    return 8'h74;
            4'd7:    return 8'h69;
            4'd8:    return 8'h6F;
            4'd9:    return 8'h6E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] val_char(input logic [3:0] pos);
        case (pos)
            4'd0:    return 8'h4B;
            4'd1:    return 8'h45;
            4'd2:    return 8'h45;
            4'd3:    return 8'h50;
            4'd4:    return 8'h2D;
            4'd5:    return 8'h41;
            4'd6:    return 8'h4C;
            4'd7:    return 8'h49;
            4'd8:    return 8'h56;
            4'd9:    return 8'h45;
            default: return 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ sv/http_request_head_parser.sv @@
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: data_byte; tuser: first_byte
// m_        out  m_tvalid/m_tready  tdata: status, method_is_post, keep_alive,
//                                   path_byte, path_byte_valid, path_is_root
//
// One byte per cycle while s_tready is high; each byte gives one result word in the cycle after it is taken.
// The parse state updates in the same cycle a byte is taken; the result register
// is the only register between a taken byte and its result word.
// aresetn is synchronous, active low; it clears the parse state and the result valid.
// s_tready stays high while the result register is empty or being drained.

module http_request_head_parser
    import hrp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic                   s_tuser,   // [0] first_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [1:0] status, [2] method_is_post,
                                                   // [3] keep_alive, [11:4] path_byte,
                                                   // [12] path_byte_valid,
                                                   // [13] path_is_root, [15:14] zero
);

    logic    accept;
    result_t res_next;

    assign accept = s_tvalid && s_tready;

    hrp_parse_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata[BYTE_W-1:0]),
        .first_byte (s_tuser),
        .res_next   (res_next)
    );

    hrp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res_next (res_next),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ sv/hrp_parse_core.sv @@
`default_nettype none

module hrp_parse_core
    import hrp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_byte,
    output result_t         res_next
);

    state_t     st_reg;
    state_t     st_next;
    logic       is_blank;
    logic [7:0] cu;
    logic       path_ok;
    logic       line_done;
    logic       is_get;
    logic       is_post;
    logic       ver_ok;
    logic       root_ok;

    assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    assign cu       = to_upper(data_byte);

    always_comb begin
        st_next   = first_byte ? STATE_RESET : st_reg;
        path_ok   = 1'b0;
        line_done = 1'b0;
        is_get    = 1'b0;
        is_post   = 1'b0;
        ver_ok    = 1'b0;

        if (st_next.phase == PH_REQ || st_next.phase == PH_HDR) begin
            if (st_next.cr_pending) begin
                st_next.cr_pending = 1'b0;
                if (data_byte == CH_LF) begin
                    line_done = 1'b1;
                end else begin
                    st_next.phase = PH_ERR;
                end
            end else if (data_byte == CH_CR) begin
                st_next.cr_pending = 1'b1;
            end else if (data_byte == CH_LF) begin
                st_next.phase = PH_ERR;
            end else if (!st_next.line_truncated) begin
                if (data_byte == CH_NUL) begin
                    st_next.line_truncated = 1'b1;
                end else begin
                    st_next.line_empty = 1'b0;
                    if (st_next.phase == PH_REQ) begin
                        unique case (st_next.step)
                            STEP_METHOD: begin
                                if (is_blank) begin
                                    st_next.step = STEP_GAP1;
                                end else begin
                                    if (st_next.method_pos >= GET_LEN ||
                                        cu != get_char(st_next.method_pos)) begin
                                        st_next.get_mismatch = 1'b1;
                                    end
                                    if (st_next.method_pos >= POST_LEN ||
                                        cu != post_char(st_next.method_pos)) begin
                                        st_next.post_mismatch = 1'b1;
                                    end
                                    if (st_next.method_pos < METH_SAT) begin
                                        st_next.method_pos = st_next.method_pos + 3'd1;
                                    end
                                end
                            end
                            STEP_GAP1, STEP_PATH: begin
                                if (is_blank) begin
                                    if (st_next.step == STEP_PATH) begin
                                        st_next.step = STEP_GAP2;
                                    end
                                end else begin
                                    st_next.step      = STEP_PATH;
                                    st_next.root_path = (st_next.path_len == 2'd0) &&
                                                        (data_byte == CH_SLASH);
                                    if (st_next.path_len < PATH_SAT) begin
                                        st_next.path_len = st_next.path_len + 2'd1;
                                    end
                                    path_ok = 1'b1;
                                end
                            end
                            STEP_GAP2, STEP_VER: begin
                                if (!(st_next.step == STEP_GAP2 && is_blank)) begin
                                    st_next.step = STEP_VER;
                                    if (st_next.version_pos >= VER_LEN ||
                                        cu != ver_char(st_next.version_pos)) begin
                                        st_next.version_mismatch = 1'b1;
                                    end
                                    if (st_next.version_pos < VER_SAT) begin
                                        st_next.version_pos = st_next.version_pos + 4'd1;
                                    end
                                end
                            end
                            default: begin
                                st_next.step = st_next.step;
                            end
                        endcase
                    end else begin
                        if (!st_next.colon_seen) begin
                            if (data_byte == CH_COLON) begin
                                st_next.colon_seen = 1'b1;
                            end else begin
                                if (st_next.key_pos >= KEY_LEN ||
                                    data_byte != key_char(st_next.key_pos)) begin
                                    st_next.key_mismatch = 1'b1;
                                end
                                if (st_next.key_pos < KEY_SAT) begin
                                    st_next.key_pos = st_next.key_pos + 4'd1;
                                end
                            end
                        end else if (st_next.value_started || !is_blank) begin
                            st_next.value_started = 1'b1;
                            if (st_next.value_pos >= VAL_LEN ||
                                cu != val_char(st_next.value_pos)) begin
                                st_next.value_mismatch = 1'b1;
                            end
                            if (st_next.value_pos < VAL_SAT) begin
                                st_next.value_pos = st_next.value_pos + 4'd1;
                            end
                        end
                    end
                end
            end
        end

        if (line_done) begin
            if (st_next.phase == PH_REQ) begin
                is_get  = (st_next.method_pos == GET_LEN) && !st_next.get_mismatch;
                is_post = (st_next.method_pos == POST_LEN) && !st_next.post_mismatch;
                ver_ok  = (st_next.step == STEP_VER) && (st_next.version_pos == VER_LEN) &&
                          !st_next.version_mismatch;
                if ((is_get || is_post) && ver_ok) begin
                    st_next.post  = is_post;
                    st_next.phase = PH_HDR;
                end else begin
                    st_next.phase = PH_ERR;
                end
            end else begin
                if (st_next.line_empty) begin
                    st_next.phase = PH_DONE;
                end else if (!st_next.colon_seen) begin
                    st_next.phase = PH_ERR;
                end else if (st_next.key_pos == KEY_LEN && !st_next.key_mismatch) begin
                    st_next.keep_alive = (st_next.value_pos == VAL_LEN) &&
                                         !st_next.value_mismatch;
                end
            end
            st_next.line_truncated = 1'b0;
            st_next.line_empty     = 1'b1;
            st_next.colon_seen     = 1'b0;
            st_next.key_pos        = 4'd0;
            st_next.key_mismatch   = 1'b0;
            st_next.value_started  = 1'b0;
            st_next.value_pos      = 4'd0;
            st_next.value_mismatch = 1'b0;
        end
    end

    assign root_ok = (st_next.phase == PH_HDR) || (st_next.phase == PH_DONE) ||
                     ((st_next.phase == PH_ERR) && st_next.post);

    always_comb begin
        res_next.status = (st_next.phase == PH_DONE) ? STATUS_DONE :
                          (st_next.phase == PH_ERR)  ? STATUS_ERROR : STATUS_INCOMPLETE;
        res_next.method_is_post  = (st_next.phase != PH_REQ) && st_next.post;
        res_next.keep_alive      = st_next.keep_alive;
        res_next.path_byte       = path_ok ? data_byte : 8'h00;
        res_next.path_byte_valid = path_ok;
        res_next.path_is_root    = root_ok && st_next.root_path;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_RESET;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && path_ok |=> st_reg.phase == PH_REQ && st_reg.step == STEP_PATH)
        else $error("path byte emitted outside the path token");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !first_byte && (st_reg.phase == PH_DONE || st_reg.phase == PH_ERR)
        |=> st_reg == $past(st_reg))
        else $error("finished request changed without a first byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_DONE || st_reg.phase == PH_ERR) |-> !st_reg.cr_pending)
        else $error("carriage return pending after the head ended");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(st_reg))
        else $error("parser state moved without an accepted word");

endmodule

`default_nettype wire

@@ sv/hrp_out_stage.sv @@
`default_nettype none

module hrp_out_stage
    import hrp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire result_t                res_next,
    output logic                        ready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
